FILE: rtl/breathing_led_chaser_macros.svh
// Assertion shorthands for the chaser RTL.
`ifndef BREATHING_LED_CHASER_MACROS_SVH
`define BREATHING_LED_CHASER_MACROS_SVH

// Invariant checked at every edge outside reset.
`define BLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Cause in this cycle, effect in the next.
`define BLC_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

FILE: rtl/blc_pkg.sv
package blc_pkg;

  localparam int LED_COUNT_DEF   = 8;
  localparam int LEVEL_COUNT_DEF = 4;

  // Number of period registers; levels above the last one share it.
  localparam int PERIOD_COUNT = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [7:0] PERIOD0_RST     = 8'd70;
  localparam logic [7:0] PERIOD1_RST     = 8'd100;
  localparam logic [7:0] PERIOD2_RST     = 8'd122;
  localparam logic [7:0] PERIOD3_RST     = 8'd141;
  localparam logic [7:0] SLOW_DIVIDE_RST = 8'd22;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PERIOD_LEVEL0 = 3'd0,
    CFG_PERIOD_LEVEL1 = 3'd1,
    CFG_PERIOD_LEVEL2 = 3'd2,
    CFG_PERIOD_LEVEL3 = 3'd3,
    CFG_SLOW_DIVIDE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic fast_tick;
    logic slow_tick;
    logic hold_right;
    logic hold_left;
    logic press_faster;
    logic press_slower;
  } in_item_t;

  typedef struct packed {
    logic [7:0] led_pattern;
    logic [7:0] digit_segments;
    logic [1:0] speed_level;
  } out_item_t;

  // 7-segment code of a decimal digit, segment a in bit 0.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/breathing_led_chaser.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (in_item_t)
// out     | output    | out_valid/out_ready| out_data (out_item_t)
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; its result appears in the
// cycle after acceptance, from the single result register.
// in_ready stays high while the result register is empty or being drained.
// A stalled output holds its result and blocks new items until taken.
// Synchronous reset restores the register defaults and the chaser state.
`include "breathing_led_chaser_macros.svh"

module breathing_led_chaser
  import blc_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEVEL_W = $clog2(LEVEL_COUNT);
  localparam int CHASE_W = $clog2(LEVEL_COUNT + 1);
  localparam int PAT_W   = (LED_COUNT > 8) ? LED_COUNT : 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_COUNT - 1);
  localparam logic [LED_COUNT-1:0] ALL_ON  = '1;
  localparam logic [LED_COUNT-1:0] LOW_LIT = ALL_ON & ~LED_COUNT'(1);
  localparam logic [LED_COUNT-1:0] TOP_LIT = {1'b0, ALL_ON[LED_COUNT-2:0]};

  logic [7:0]           period [PERIOD_COUNT];
  logic [7:0]           slow_divide;
  logic [7:0]           pwm_count;
  logic [7:0]           duty;
  logic                 ramp_down;
  logic [7:0]           slow_count;
  logic [CHASE_W-1:0]   chase_steps;
  logic [LED_COUNT-1:0] led_mask;
  logic                 move_right;
  logic [LEVEL_W-1:0]   level;

  logic [7:0]           pwm_count_next;
  logic [7:0]           duty_next;
  logic                 ramp_down_next;
  logic [7:0]           slow_count_next;
  logic [CHASE_W-1:0]   chase_steps_next;
  logic [LED_COUNT-1:0] led_mask_next;
  logic                 move_right_next;
  logic [LEVEL_W-1:0]   level_next;
  out_item_t            out_data_next;

  logic                 in_acc;
  logic [3:0]           level_wide;
  logic [1:0]           period_sel;
  logic [7:0]           cur_period;
  logic [PAT_W-1:0]     mask_wide;
  logic [3:0]           level_wide_next;
  logic                 up;
  logic                 down;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign level_wide = 4'(level);
  assign period_sel = (level_wide < 4'(PERIOD_COUNT)) ? level_wide[1:0]
                                                      : 2'(PERIOD_COUNT - 1);
  assign cur_period = period[period_sel];
  assign mask_wide  = PAT_W'(led_mask);

  always_comb begin
    pwm_count_next   = in_data.fast_tick ? pwm_count + 8'd1 : pwm_count;
    slow_count_next  = (in_data.slow_tick && slow_count != 8'hff) ? slow_count + 8'd1
                                                                  : slow_count;
    duty_next        = duty;
    ramp_down_next   = ramp_down;
    chase_steps_next = chase_steps;
    led_mask_next    = led_mask;
    move_right_next  = move_right;

    // Period end: restart the counter and step the triangle ramp.
    if (pwm_count_next >= cur_period) begin
      pwm_count_next = '0;
      if (!ramp_down_next) begin
        if (duty_next != 8'hff) duty_next = duty_next + 8'd1;
      end else begin
        if (duty_next != 8'h00) duty_next = duty_next - 8'd1;
      end
    end
    if (duty_next == 8'h00) begin
      ramp_down_next = 1'b0;
    end else if (duty_next >= cur_period) begin
      ramp_down_next = 1'b1;
    end

    out_data_next.led_pattern = (pwm_count_next < duty_next) ? mask_wide[7:0] : 8'hff;

    if (slow_count_next >= slow_divide) begin
      chase_steps_next = chase_steps_next + CHASE_W'(1);
      slow_count_next  = '0;
    end
    // Enough sub-steps at this level: move the lit LED, restart the ramp.
    if (chase_steps_next >= CHASE_W'(level) + CHASE_W'(1)) begin
      if (move_right) begin
        led_mask_next = {led_mask[0], led_mask[LED_COUNT-1:1]};
      end else begin
        led_mask_next = {led_mask[LED_COUNT-2:0], led_mask[LED_COUNT-1]};
      end
      chase_steps_next = '0;
      pwm_count_next   = '0;
      ramp_down_next   = 1'b0;
      duty_next        = '0;
    end

    // Bounce at the ends of the row; held keys override.
    if (led_mask_next == TOP_LIT) begin
      move_right_next = 1'b1;
    end else if (led_mask_next == LOW_LIT) begin
      move_right_next = 1'b0;
    end
    if (in_data.hold_right) move_right_next = 1'b0;
    if (in_data.hold_left)  move_right_next = 1'b1;

    up   = in_data.press_faster && !in_data.press_slower;
    down = in_data.press_slower && !in_data.press_faster;
    level_next = level;
    if (up && level != LEVEL_MAX) begin
      level_next = level + LEVEL_W'(1);
    end else if (down && level != '0) begin
      level_next = level - LEVEL_W'(1);
    end

    level_wide_next              = 4'(level_next);
    out_data_next.digit_segments = seg_code(level_wide_next + 4'd1);
    out_data_next.speed_level    = level_wide_next[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period[0]   <= PERIOD0_RST;
      period[1]   <= PERIOD1_RST;
      period[2]   <= PERIOD2_RST;
      period[3]   <= PERIOD3_RST;
      slow_divide <= SLOW_DIVIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD_LEVEL0: period[0]   <= cfg_data;
        CFG_PERIOD_LEVEL1: period[1]   <= cfg_data;
        CFG_PERIOD_LEVEL2: period[2]   <= cfg_data;
        CFG_PERIOD_LEVEL3: period[3]   <= cfg_data;
        CFG_SLOW_DIVIDE:   slow_divide <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count   <= '0;
      duty        <= '0;
      ramp_down   <= 1'b0;
      slow_count  <= '0;
      chase_steps <= '0;
      led_mask    <= LOW_LIT;
      move_right  <= 1'b0;
      level       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        pwm_count   <= pwm_count_next;
        duty        <= duty_next;
        ramp_down   <= ramp_down_next;
        slow_count  <= slow_count_next;
        chase_steps <= chase_steps_next;
        led_mask    <= led_mask_next;
        move_right  <= move_right_next;
        level       <= level_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data <= out_data_next;
  end

  `BLC_ASSERT(a_one_led_lit, $countones(~led_mask) == 1, "led mask lost its single lit LED")
  `BLC_ASSERT(a_level_range, level <= LEVEL_MAX, "speed level out of range")
  `BLC_ASSERT_NEXT(a_result_follows, in_acc, out_valid, "accepted item gave no result")
  `BLC_ASSERT_NEXT(a_level_shown, in_acc, out_data.speed_level == 2'(level),
                   "shown speed level differs from stored level")
  `BLC_ASSERT_NEXT(a_idle_holds, !in_acc, $stable(level) && $stable(led_mask),
                   "chaser state moved without an item")

endmodule

FILE: tb/sv/chaser_check.sv
`timescale 1ns / 1ps

module chaser_check
  import blc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending
);

  localparam logic [7:0] MASK_FIRST_LIT = 8'hfe;
  localparam logic [7:0] MASK_LAST_LIT  = 8'h7f;
  localparam logic [7:0] LEVEL_DIGIT [4] = '{8'h06, 8'h5B, 8'h4F, 8'h66};

  logic [7:0] period_reg [PERIOD_COUNT];
  logic [7:0] divide_reg;
  logic [7:0] pwm_cnt;
  logic [7:0] duty_lvl;
  logic [7:0] slow_cnt;
  logic [7:0] lit_mask;
  logic [2:0] sub_steps;
  logic [1:0] speed;
  logic       ramping_down;
  logic       rotate_right;
  out_item_t  expected_frames [$];
  int         errors = 0;

  // One service pass: update the chaser copy and return the LED frame it shows.
  function automatic out_item_t next_led_frame(input in_item_t pass);
    logic [7:0] period;
    out_item_t  frame;
    int         lv;
    if (pass.fast_tick) pwm_cnt = pwm_cnt + 8'd1;
    if (pass.slow_tick && slow_cnt != 8'hff) slow_cnt = slow_cnt + 8'd1;
    period = period_reg[speed];
    if (pwm_cnt >= period) begin
      pwm_cnt = 8'd0;
      if (!ramping_down) begin
        if (duty_lvl != 8'hff) duty_lvl = duty_lvl + 8'd1;
      end else if (duty_lvl != 8'd0) begin
        duty_lvl = duty_lvl - 8'd1;
      end
    end
    if (duty_lvl == 8'd0) ramping_down = 1'b0;
    else if (duty_lvl >= period) ramping_down = 1'b1;
    frame.led_pattern = (pwm_cnt < duty_lvl) ? lit_mask : 8'hff;
    if (slow_cnt >= divide_reg) begin
      sub_steps = sub_steps + 3'd1;
      slow_cnt = 8'd0;
    end
    // advance the lit LED and restart the breathing ramp
    if (int'(sub_steps) >= int'(speed) + 1) begin
      lit_mask = rotate_right ? {lit_mask[0], lit_mask[7:1]} : {lit_mask[6:0], lit_mask[7]};
      sub_steps = 3'd0;
      pwm_cnt = 8'd0;
      ramping_down = 1'b0;
      duty_lvl = 8'd0;
    end
    if (lit_mask == MASK_LAST_LIT) rotate_right = 1'b1;
    else if (lit_mask == MASK_FIRST_LIT) rotate_right = 1'b0;
    if (pass.hold_right) rotate_right = 1'b0;
    if (pass.hold_left) rotate_right = 1'b1;
    lv = int'(speed);
    if (pass.press_faster) lv++;
    if (pass.press_slower) lv--;
    if (lv < 0) lv = 0;
    else if (lv > 3) lv = 3;
    speed = lv[1:0];
    frame.digit_segments = LEVEL_DIGIT[speed];
    frame.speed_level = speed;
    return frame;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      period_reg[0] = PERIOD0_RST;
      period_reg[1] = PERIOD1_RST;
      period_reg[2] = PERIOD2_RST;
      period_reg[3] = PERIOD3_RST;
      divide_reg = SLOW_DIVIDE_RST;
      pwm_cnt = 8'd0;
      duty_lvl = 8'd0;
      slow_cnt = 8'd0;
      lit_mask = MASK_FIRST_LIT;
      sub_steps = 3'd0;
      speed = 2'd0;
      ramping_down = 1'b0;
      rotate_right = 1'b0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD_LEVEL0: period_reg[0] = cfg_data;
          CFG_PERIOD_LEVEL1: period_reg[1] = cfg_data;
          CFG_PERIOD_LEVEL2: period_reg[2] = cfg_data;
          CFG_PERIOD_LEVEL3: period_reg[3] = cfg_data;
          CFG_SLOW_DIVIDE:   divide_reg = cfg_data;
          default: ;
        endcase
      end
      // a result taken at this edge always belongs to an earlier item
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected frame led=%h seg=%h level=%0d", $realtime,
                     out_data.led_pattern, out_data.digit_segments, out_data.speed_level);
        end else begin
          want = expected_frames.pop_front();
          if (want.led_pattern !== out_data.led_pattern ||
              want.digit_segments !== out_data.digit_segments ||
              want.speed_level !== out_data.speed_level) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp led=%h seg=%h level=%0d, got led=%h seg=%h level=%0d",
                       $realtime, want.led_pattern, want.digit_segments, want.speed_level,
                       out_data.led_pattern, out_data.digit_segments, out_data.speed_level);
          end
        end
      end
      if (in_valid && in_ready) expected_frames.push_back(next_led_frame(in_data));
    end
    mismatches <= errors;
    pending <= expected_frames.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
  import blc_pkg::*;
();

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fails;
  int                     pending;
  int                     idle_odds = 4;
  int                     stall_left = 0;

  always #6 clk = ~clk;

  breathing_led_chaser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chaser_check frame_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fails),
    .pending    (pending)
  );

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (rst || idle_odds == 0) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, idle_odds * 2) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t key_pass(input logic fast, input logic slow, input logic hr,
                                        input logic hl, input logic up, input logic down);
    in_item_t pass;
    pass.fast_tick = fast;
    pass.slow_tick = slow;
    pass.hold_right = hr;
    pass.hold_left = hl;
    pass.press_faster = up;
    pass.press_slower = down;
    return pass;
  endfunction

  function automatic in_item_t random_pass();
    return key_pass($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
  endfunction

  task automatic send_pass(input in_item_t pass);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pass;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected frame has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
                                input logic [7:0] p3, input logic [7:0] divide);
    set_reg(CFG_PERIOD_LEVEL0, p0);
    set_reg(CFG_PERIOD_LEVEL1, p1);
    set_reg(CFG_PERIOD_LEVEL2, p2);
    set_reg(CFG_PERIOD_LEVEL3, p3);
    set_reg(CFG_SLOW_DIVIDE, divide);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed passes at the reset settings.
    send_pass(key_pass(0, 0, 0, 0, 0, 0));
    send_pass(key_pass(1, 0, 0, 0, 0, 0));
    send_pass(key_pass(0, 1, 0, 0, 0, 0));
    send_pass(key_pass(1, 1, 1, 1, 1, 1));
    send_pass(key_pass(1, 1, 1, 0, 0, 0));
    send_pass(key_pass(1, 1, 0, 1, 0, 0));
    send_pass(key_pass(1, 1, 1, 1, 0, 0));
    repeat (4) send_pass(key_pass(1, 1, 0, 0, 1, 0));
    send_pass(key_pass(1, 0, 0, 0, 1, 1));
    repeat (4) send_pass(key_pass(1, 1, 0, 0, 0, 1));
    send_pass(key_pass(1, 1, 0, 0, 1, 1));
    repeat (3) send_pass(key_pass(1, 1, 0, 0, 0, 0));

    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        1: apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        // zero period restarts the counter every pass; zero divide steps every pass
        2: apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        5: apply_settings(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                          8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                          8'($urandom_range(20, 120)));
        7: begin
          idle_odds <= 0;
          apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                         8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                         8'($urandom_range(2, 30)));
        end
        default: apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                                8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                                8'($urandom_range(2, 30)));
      endcase
      repeat (200) send_pass(random_pass());
    end

    settle();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
